@@ rtl/core/target_follow_pid_drive_core_macros.svh @@
// Assertion macros for the target follow drive core.
// Each macro expects clk and rst_n in the scope of its use.
`ifndef TARGET_FOLLOW_PID_DRIVE_CORE_MACROS_SVH
`define TARGET_FOLLOW_PID_DRIVE_CORE_MACROS_SVH

// Same-cycle implication, off while reset is held
`define TFPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held
`define TFPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Check what a reset cycle leaves behind
`define TFPD_ASSERT_AFTER_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/tfpd_pkg.sv @@
// Shared types and constants for the target follow drive core.
// No dependencies.
`default_nettype none

package tfpd_pkg;

  localparam int GAIN_W     = 12;
  localparam int DUTY_W     = 7;
  localparam int CFG_IDX_W  = 3;

  typedef logic signed [GAIN_W-1:0] gain_t;
  typedef logic [DUTY_W-1:0]        duty_t;

  // Gains of one PID loop, Q4.8 signed
  typedef struct packed {
    gain_t kp;
    gain_t ki;
    gain_t kd;
  } pid_gains_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RUN_KP        = 3'd0,
    REG_RUN_KI        = 3'd1,
    REG_RUN_KD        = 3'd2,
    REG_TURN_KP       = 3'd3,
    REG_TURN_KI       = 3'd4,
    REG_TURN_KD       = 3'd5,
    REG_SPEED_CEILING = 3'd6,
    REG_SPEED_FLOOR   = 3'd7
  } cfg_reg_t;

  localparam duty_t DUTY_LIMIT = 7'd100;

  // Register reset values
  localparam gain_t RST_RUN_KP        = 12'sd77;
  localparam gain_t RST_RUN_KI        = 12'sd0;
  localparam gain_t RST_RUN_KD        = 12'sd256;
  localparam gain_t RST_TURN_KP       = 12'sd102;
  localparam gain_t RST_TURN_KI       = 12'sd0;
  localparam gain_t RST_TURN_KD       = 12'sd0;
  localparam duty_t RST_SPEED_CEILING = 7'd20;
  localparam duty_t RST_SPEED_FLOOR   = 7'd10;

endpackage

`default_nettype wire

@@ rtl/core/target_follow_pid_drive_core.sv @@
// Target follow drive core: two PID loops and a differential wheel mixer.
// Depends on tfpd_pkg and tfpd_pid_term.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one target per frame: box height
//   and box center x. Result channel (out_valid/out_ready) returns direction
//   and clamped duty for the right and left wheel.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the six
//   PID gains and the speed ceiling and floor; cfg_ready is always high.
//   Write configuration only while no item is in flight.
// Timing:
//   An accepted item waits in the input register, moves to the result
//   register when that is free and then shows on out_valid. One item per
//   cycle is sustained while out_ready is high: integrator and previous-error
//   state update at acceptance, and the input register to result register
//   pass (three gain multiplies, sum, mix, clamp) is combinational.
// Reset (rst_n low at a clock edge) empties both registers, clears the
//   integrators and previous errors, and restores all gains and clamps.
// Stall: while out_ready is low the result holds; one more item waits in
//   the input register, after which in_ready drops.
`default_nettype none

module target_follow_pid_drive_core #(
  parameter int HALF_WIDTH     = 200,
  parameter int HALF_HEIGHT    = 150,
  parameter int COORD_BITS     = 10,
  parameter int SUM_BITS       = 24,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [COORD_BITS-1:0]           in_box_height,
  input  logic [COORD_BITS-1:0]           in_target_x,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_right_forward,
  output logic [tfpd_pkg::DUTY_W-1:0]     out_right_duty,
  output logic                            out_left_forward,
  output logic [tfpd_pkg::DUTY_W-1:0]     out_left_duty,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tfpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tfpd_pkg::GAIN_W-1:0]     cfg_data
);
  import tfpd_pkg::*;

  localparam int ERR_W = ((COORD_BITS > 10) ? COORD_BITS : 10) + 1;
  localparam int ACC_W = SUM_BITS + 14;
  localparam int Q_W   = ACC_W - GAIN_FRAC_BITS;
  localparam int MIX_W = Q_W + 2;

  localparam logic signed [SUM_BITS:0] SAT_HI = {2'b00, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS:0] SAT_LO = -SAT_HI;

  function automatic logic signed [SUM_BITS-1:0] sat_sum(input logic signed [SUM_BITS:0] v);
    logic signed [SUM_BITS:0] t;
    t = v;
    if (v > SAT_HI) begin
      t = SAT_HI;
    end else if (v < SAT_LO) begin
      t = SAT_LO;
    end
    return t[SUM_BITS-1:0];
  endfunction

  // Configuration registers
  pid_gains_t run_gains_r;
  pid_gains_t turn_gains_r;
  duty_t      speed_ceiling_r;
  duty_t      speed_floor_r;

  // Loop state
  logic signed [ERR_W-1:0]    prev_h_r, prev_x_r;
  logic signed [SUM_BITS-1:0] sum_h_r, sum_x_r;
  logic signed [SUM_BITS-1:0] sum_h_nxt, sum_x_nxt;

  // Input register
  logic                       a_v_r;
  logic signed [ERR_W-1:0]    a_eh_r, a_ex_r;
  logic signed [ERR_W:0]      a_dh_r, a_dx_r;
  logic signed [SUM_BITS-1:0] a_sh_r, a_sx_r;

  // Result register
  logic  o_v_r;
  logic  o_rf_r, o_lf_r;
  duty_t o_rd_r, o_ld_r;
  logic  o_rf_nxt, o_lf_nxt;
  duty_t o_rd_nxt, o_ld_nxt;

  logic signed [ERR_W-1:0] eh_in, ex_in;
  logic signed [ERR_W:0]   dh_in, dx_in;
  logic                    in_acc;
  logic                    b_load;

  logic signed [Q_W-1:0]   q_h, q_t;
  logic signed [MIX_W-1:0] fwd, turn, r_val, l_val;
  logic [MIX_W-1:0]        r_mag, l_mag;

  // Handshake
  assign in_acc    = in_valid && in_ready;
  assign b_load    = a_v_r && (!o_v_r || out_ready);
  assign in_ready  = !a_v_r || b_load;
  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_gains_r     <= '{kp: RST_RUN_KP, ki: RST_RUN_KI, kd: RST_RUN_KD};
      turn_gains_r    <= '{kp: RST_TURN_KP, ki: RST_TURN_KI, kd: RST_TURN_KD};
      speed_ceiling_r <= RST_SPEED_CEILING;
      speed_floor_r   <= RST_SPEED_FLOOR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RUN_KP:        run_gains_r.kp  <= cfg_data;
        REG_RUN_KI:        run_gains_r.ki  <= cfg_data;
        REG_RUN_KD:        run_gains_r.kd  <= cfg_data;
        REG_TURN_KP:       turn_gains_r.kp <= cfg_data;
        REG_TURN_KI:       turn_gains_r.ki <= cfg_data;
        REG_TURN_KD:       turn_gains_r.kd <= cfg_data;
        REG_SPEED_CEILING: speed_ceiling_r <= cfg_data[DUTY_W-1:0];
        REG_SPEED_FLOOR:   speed_floor_r   <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Form errors, deltas and saturated sums of the arriving item
  always_comb begin
    eh_in     = ERR_W'(in_box_height) - ERR_W'(HALF_HEIGHT);
    ex_in     = ERR_W'(in_target_x) - ERR_W'(HALF_WIDTH);
    dh_in     = (ERR_W+1)'(eh_in) - (ERR_W+1)'(prev_h_r);
    dx_in     = (ERR_W+1)'(ex_in) - (ERR_W+1)'(prev_x_r);
    sum_h_nxt = sat_sum((SUM_BITS+1)'(sum_h_r) + (SUM_BITS+1)'(eh_in));
    sum_x_nxt = sat_sum((SUM_BITS+1)'(sum_x_r) + (SUM_BITS+1)'(ex_in));
  end

  // Advance loop state on acceptance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_h_r <= '0;
      prev_x_r <= '0;
      sum_h_r  <= '0;
      sum_x_r  <= '0;
    end else if (in_acc) begin
      prev_h_r <= eh_in;
      prev_x_r <= ex_in;
      sum_h_r  <= sum_h_nxt;
      sum_x_r  <= sum_x_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (in_acc) begin
      a_v_r <= 1'b1;
    end else if (b_load) begin
      a_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_eh_r <= eh_in;
      a_ex_r <= ex_in;
      a_dh_r <= dh_in;
      a_dx_r <= dx_in;
      a_sh_r <= sum_h_r;
      a_sx_r <= sum_x_r;
    end
  end

  // Distance and turn loop outputs
  tfpd_pid_term #(
    .ERR_W  (ERR_W),
    .SUM_W  (SUM_BITS),
    .FRAC_W (GAIN_FRAC_BITS)
  ) u_pid_run (
    .err       (a_eh_r),
    .err_delta (a_dh_r),
    .err_sum   (a_sh_r),
    .gains     (run_gains_r),
    .q         (q_h)
  );

  tfpd_pid_term #(
    .ERR_W  (ERR_W),
    .SUM_W  (SUM_BITS),
    .FRAC_W (GAIN_FRAC_BITS)
  ) u_pid_turn (
    .err       (a_ex_r),
    .err_delta (a_dx_r),
    .err_sum   (a_sx_r),
    .gains     (turn_gains_r),
    .q         (q_t)
  );

  // Mix differentially and clamp against the right wheel
  always_comb begin
    fwd  = -MIX_W'(q_h);
    turn = MIX_W'(q_t);
    if (!fwd[MIX_W-1]) begin
      r_val = fwd - turn;
      l_val = fwd + turn;
    end else begin
      l_val = fwd - turn;
      r_val = fwd + turn;
    end
    r_mag = r_val[MIX_W-1] ? MIX_W'(-r_val) : MIX_W'(r_val);
    l_mag = l_val[MIX_W-1] ? MIX_W'(-l_val) : MIX_W'(l_val);

    o_rf_nxt = !r_val[MIX_W-1];
    o_lf_nxt = !l_val[MIX_W-1];

    if (r_mag > MIX_W'(speed_ceiling_r)) begin
      o_rd_nxt = speed_ceiling_r;
      o_ld_nxt = speed_ceiling_r;
    end else if (r_mag < MIX_W'(speed_floor_r)) begin
      o_rd_nxt = speed_floor_r;
      o_ld_nxt = speed_floor_r;
    end else begin
      o_rd_nxt = r_mag[DUTY_W-1:0];
      o_ld_nxt = (l_mag > MIX_W'(DUTY_LIMIT)) ? DUTY_LIMIT : l_mag[DUTY_W-1:0];
    end

    // Hold both duties at the hard limit
    if (o_rd_nxt > DUTY_LIMIT) begin
      o_rd_nxt = DUTY_LIMIT;
    end
    if (o_ld_nxt > DUTY_LIMIT) begin
      o_ld_nxt = DUTY_LIMIT;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (b_load) begin
      o_v_r <= 1'b1;
    end else if (out_ready) begin
      o_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      o_rf_r <= o_rf_nxt;
      o_lf_r <= o_lf_nxt;
      o_rd_r <= o_rd_nxt;
      o_ld_r <= o_ld_nxt;
    end
  end

  assign out_valid         = o_v_r;
  assign out_right_forward = o_rf_r;
  assign out_right_duty    = o_rd_r;
  assign out_left_forward  = o_lf_r;
  assign out_left_duty     = o_ld_r;

endmodule

`default_nettype wire

@@ rtl/core/tfpd_pid_term.sv @@
// One PID output term: kp*e + ki*S + kd*de, scaled down with truncation toward zero.
// Depends on tfpd_pkg for the gain struct.
`default_nettype none

module tfpd_pid_term #(
  parameter int ERR_W  = 11,
  parameter int SUM_W  = 24,
  parameter int FRAC_W = 8
) (
  input  logic signed [ERR_W-1:0]             err,
  input  logic signed [ERR_W:0]               err_delta,
  input  logic signed [SUM_W-1:0]             err_sum,
  input  tfpd_pkg::pid_gains_t                gains,
  output logic signed [SUM_W+14-FRAC_W-1:0]   q
);
  import tfpd_pkg::*;

  localparam int ACC_W = SUM_W + 14;

  logic signed [GAIN_W+ERR_W-1:0] p_prop;
  logic signed [GAIN_W+SUM_W-1:0] p_int;
  logic signed [GAIN_W+ERR_W:0]   p_der;
  logic signed [ACC_W-1:0]        acc;
  logic signed [ACC_W-1:0]        acc_adj;

  // Form the three products in parallel
  assign p_prop = gains.kp * err;
  assign p_int  = gains.ki * err_sum;
  assign p_der  = gains.kd * err_delta;

  assign acc = ACC_W'(p_prop) + ACC_W'(p_int) + ACC_W'(p_der);

  // Bias negative sums so the arithmetic shift truncates toward zero
  assign acc_adj = acc[ACC_W-1]
                 ? acc + {{(ACC_W-FRAC_W){1'b0}}, {FRAC_W{1'b1}}}
                 : acc;

  assign q = acc_adj[ACC_W-1:FRAC_W];

endmodule

`default_nettype wire

@@ rtl/core/tfpd_port_checker.sv @@
// Port-level assertions for the target follow drive core, bound to the top level.
// Depends on tfpd_pkg and target_follow_pid_drive_core_macros.svh.
`default_nettype none

`include "target_follow_pid_drive_core_macros.svh"

module tfpd_port_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_right_forward,
  input logic [tfpd_pkg::DUTY_W-1:0] out_right_duty,
  input logic                        out_left_forward,
  input logic [tfpd_pkg::DUTY_W-1:0] out_left_duty
);
  import tfpd_pkg::*;

  // Stalled item stays offered
  `TFPD_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // Stalled item keeps its payload
  `TFPD_ASSERT_NEXT(a_stall_stable, out_valid && !out_ready, $stable(out_right_duty) && $stable(out_left_duty) && $stable(out_right_forward) && $stable(out_left_forward), "result changed while stalled")

  // Duties of an offered result never exceed the hard limit
  `TFPD_ASSERT_NOW(a_duty_limit, out_valid, (out_right_duty <= DUTY_LIMIT) && (out_left_duty <= DUTY_LIMIT), "duty above limit")

  // Empty result register always leaves room for a new item
  `TFPD_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")

  // Reset empties the result register
  `TFPD_ASSERT_AFTER_RESET(a_reset_empty, !out_valid, "result valid after reset")

endmodule

bind target_follow_pid_drive_core tfpd_port_checker u_tfpd_port_checker (.*);

`default_nettype wire
